// ----- src/bcd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the biquad cascade filter.
package bcd_pkg;

   localparam int DEF_MAX_STAGES = 8;
   localparam int SAMPLE_W       = 32;
   localparam int ACC_W          = 64;
   localparam int NUM_COEF       = 5;
   localparam int DLY_SHIFT      = 28;

   // Coefficient slots within one stage.
   localparam logic [2:0] SLOT_B0 = 3'd0;
   localparam logic [2:0] SLOT_B1 = 3'd1;
   localparam logic [2:0] SLOT_B2 = 3'd2;
   localparam logic [2:0] SLOT_A1 = 3'd3;
   localparam logic [2:0] SLOT_A2 = 3'd4;

   // Input word kinds carried on tuser.
   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_P0,
      ST_P1,
      ST_P2,
      ST_P3,
      ST_P4,
      ST_P5,
      ST_P6,
      ST_P7,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_ADD,
      ACC_LOAD_DLY,
      ACC_LOAD
   } acc_op_type;

   typedef enum logic [1:0] {
      SEL_Y,
      SEL_D1,
      SEL_D2
   } acc_sel_type;

   typedef struct packed {
      logic        x_load;
      logic        x_from_y;
      logic        mul_en;
      logic        mul_use_y;
      acc_op_type  acc_op;
      acc_sel_type acc_sel;
      logic        y_load;
      acc_sel_type rnd_sel;
   } mac_ctrl_type;

endpackage

// ----- src/bcd_ram.sv -----
`timescale 1ns / 1ps
// Single write port, single read port memory with per-entry valid bits.
module bcd_ram #(
   parameter int DEPTH = 40,
   parameter int AW    = 6,
   parameter int W     = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [W-1:0]  wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [W-1:0]  rd_data
);

   logic [W-1:0]     mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [W-1:0]     rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // An entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/bcd_mac.sv -----
`timescale 1ns / 1ps
// Shared multiply-accumulate unit with the stage accumulators and rounding.
module bcd_mac (
   input  logic                                clock,
   input  bcd_pkg::mac_ctrl_type               ctrl,
   input  logic signed [bcd_pkg::SAMPLE_W-1:0] sample,
   input  logic signed [bcd_pkg::SAMPLE_W-1:0] coef_rd,
   input  logic signed [bcd_pkg::SAMPLE_W-1:0] dly_rd,
   output logic signed [bcd_pkg::SAMPLE_W-1:0] rnd_out,
   output logic signed [bcd_pkg::SAMPLE_W-1:0] y_out
);

   import bcd_pkg::*;

   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SAMPLE_W-1:0] y_ff, y_in;
   logic signed [SAMPLE_W-1:0] mul_b;
   logic signed [ACC_W-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_y_ff, acc_y_in;
   logic signed [ACC_W-1:0]    acc_d1_ff, acc_d1_in;
   logic signed [ACC_W-1:0]    acc_d2_ff, acc_d2_in;
   logic signed [ACC_W-1:0]    acc_cur;
   logic signed [ACC_W-1:0]    add_a;
   logic signed [ACC_W-1:0]    sum;
   logic signed [ACC_W-1:0]    rnd_src;

   // Round half up from Q5.59 to Q1.31 and saturate.
   function automatic logic signed [SAMPLE_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0]              s;
      logic signed [ACC_W-DLY_SHIFT-1:0]    r;
      logic signed [SAMPLE_W-1:0]           res;
      s = a + (ACC_W'(1) <<< (DLY_SHIFT - 1));
      r = s[ACC_W-1:DLY_SHIFT];
      if (r > (ACC_W-DLY_SHIFT)'(2147483647)) begin
         res = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (r < -(ACC_W-DLY_SHIFT)'(64'sd2147483648)) begin
         res = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         res = r[SAMPLE_W-1:0];
      end
      return res;
   endfunction

   assign mul_b   = ctrl.mul_use_y ? y_ff : x_ff;
   assign prod_in = ACC_W'(coef_rd) * ACC_W'(mul_b);

   always_comb begin
      case (ctrl.acc_sel)
         SEL_Y:   acc_cur = acc_y_ff;
         SEL_D1:  acc_cur = acc_d1_ff;
         SEL_D2:  acc_cur = acc_d2_ff;
         default: acc_cur = acc_y_ff;
      endcase
   end

   always_comb begin
      case (ctrl.acc_op)
         ACC_ADD:      add_a = acc_cur;
         ACC_LOAD_DLY: add_a = ACC_W'(dly_rd) <<< DLY_SHIFT;
         ACC_LOAD:     add_a = '0;
         default:      add_a = acc_cur;
      endcase
   end

   // Each product is Q3.61; the floor shift by two brings it to Q5.59.
   assign sum = add_a + (prod_ff >>> 2);

   always_comb begin
      acc_y_in  = acc_y_ff;
      acc_d1_in = acc_d1_ff;
      acc_d2_in = acc_d2_ff;
      if (ctrl.acc_op != ACC_HOLD) begin
         case (ctrl.acc_sel)
            SEL_Y:   acc_y_in  = sum;
            SEL_D1:  acc_d1_in = sum;
            SEL_D2:  acc_d2_in = sum;
            default: acc_y_in  = sum;
         endcase
      end
   end

   always_comb begin
      case (ctrl.rnd_sel)
         SEL_Y:   rnd_src = acc_y_ff;
         SEL_D1:  rnd_src = acc_d1_ff;
         SEL_D2:  rnd_src = acc_d2_ff;
         default: rnd_src = acc_y_ff;
      endcase
   end

   assign rnd_out = rnd_sat(rnd_src);

   always_comb begin
      y_in = ctrl.y_load ? rnd_out : y_ff;
      if (ctrl.x_load) begin
         x_in = sample;
      end else if (ctrl.x_from_y) begin
         x_in = y_ff;
      end else begin
         x_in = x_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      acc_y_ff  <= acc_y_in;
      acc_d1_ff <= acc_d1_in;
      acc_d2_ff <= acc_d2_in;
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign y_out = y_ff;

endmodule

// ----- src/bcd_seq.sv -----
`timescale 1ns / 1ps
// Sequencer: input handshake, per-stage step control and the result register.
module bcd_seq #(
   parameter int MAX_STAGES = bcd_pkg::DEF_MAX_STAGES,
   parameter int SW         = 3,
   parameter int CAW        = 6,
   parameter int DAW        = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_op,
   input  logic                                req_block_end,
   input  logic [2:0]                          req_coef_stage,
   input  logic [2:0]                          req_coef_slot,
   input  logic [SW-1:0]                       last_stage,
   input  logic signed [bcd_pkg::SAMPLE_W-1:0] y,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bcd_pkg::SAMPLE_W-1:0]        rsp_tdata,
   output logic                                rsp_tlast,
   output bcd_pkg::mac_ctrl_type               mac_ctrl,
   output logic                                coef_wr_en,
   output logic [CAW-1:0]                      coef_wr_addr,
   output logic                                coef_rd_en,
   output logic [CAW-1:0]                      coef_rd_addr,
   output logic                                dly_rd_en,
   output logic [DAW-1:0]                      dly_rd_addr,
   output logic                                dly_wr_en,
   output logic [DAW-1:0]                      dly_wr_addr
);

   import bcd_pkg::*;

   state_type             state_ff, state_in;
   logic [SW-1:0]         stage_ff, stage_in;
   logic [SW-1:0]         last_ff, last_in;
   logic                  blk_ff, blk_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  accept;
   logic                  out_load;
   logic [SW-1:0]         stage_next;
   logic [SW-1:0]         rd_stage;
   logic [2:0]            rd_slot;
   logic                  dly_rd_odd;
   logic                  dly_wr_odd;

   function automatic logic [CAW-1:0] coef_addr(input logic [CAW-1:0] s, input logic [2:0] slot);
      return CAW'(s * CAW'(NUM_COEF) + CAW'(slot));
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign stage_next = SW'(stage_ff + SW'(1));

   always_comb begin
      state_in   = state_ff;
      stage_in   = stage_ff;
      last_in    = last_ff;
      blk_in     = blk_ff;
      req_tready = 1'b0;
      out_load   = 1'b0;
      coef_wr_en = 1'b0;
      coef_rd_en = 1'b0;
      dly_rd_en  = 1'b0;
      dly_wr_en  = 1'b0;
      rd_stage   = stage_ff;
      rd_slot    = SLOT_B0;
      dly_rd_odd = 1'b0;
      dly_wr_odd = 1'b0;
      mac_ctrl   = '{x_load: 1'b0, x_from_y: 1'b0, mul_en: 1'b0, mul_use_y: 1'b0,
                     acc_op: ACC_HOLD, acc_sel: SEL_Y, y_load: 1'b0, rnd_sel: SEL_Y};

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               if (req_op == OP_LOAD) begin
                  coef_wr_en = (req_coef_slot < 3'(NUM_COEF)) &&
                               (32'(req_coef_stage) < MAX_STAGES);
               end else begin
                  mac_ctrl.x_load = 1'b1;
                  stage_in        = '0;
                  last_in         = last_stage;
                  blk_in          = req_block_end;
                  state_in        = ST_P0;
               end
            end
         end
         ST_P0: begin
            coef_rd_en = 1'b1;
            rd_slot    = SLOT_B0;
            dly_rd_en  = 1'b1;
            state_in   = ST_P1;
         end
         ST_P1: begin
            mac_ctrl.mul_en = 1'b1;
            coef_rd_en      = 1'b1;
            rd_slot         = SLOT_B1;
            state_in        = ST_P2;
         end
         ST_P2: begin
            mac_ctrl.acc_op  = ACC_LOAD_DLY;
            mac_ctrl.acc_sel = SEL_Y;
            mac_ctrl.mul_en  = 1'b1;
            coef_rd_en       = 1'b1;
            rd_slot          = SLOT_B2;
            dly_rd_en        = 1'b1;
            dly_rd_odd       = 1'b1;
            state_in         = ST_P3;
         end
         ST_P3: begin
            mac_ctrl.acc_op  = ACC_LOAD_DLY;
            mac_ctrl.acc_sel = SEL_D1;
            mac_ctrl.mul_en  = 1'b1;
            mac_ctrl.y_load  = 1'b1;
            mac_ctrl.rnd_sel = SEL_Y;
            coef_rd_en       = 1'b1;
            rd_slot          = SLOT_A1;
            state_in         = ST_P4;
         end
         ST_P4: begin
            mac_ctrl.acc_op    = ACC_LOAD;
            mac_ctrl.acc_sel   = SEL_D2;
            mac_ctrl.mul_en    = 1'b1;
            mac_ctrl.mul_use_y = 1'b1;
            coef_rd_en         = 1'b1;
            rd_slot            = SLOT_A2;
            state_in           = ST_P5;
         end
         ST_P5: begin
            mac_ctrl.acc_op    = ACC_ADD;
            mac_ctrl.acc_sel   = SEL_D1;
            mac_ctrl.mul_en    = 1'b1;
            mac_ctrl.mul_use_y = 1'b1;
            state_in           = ST_P6;
         end
         ST_P6: begin
            mac_ctrl.acc_op  = ACC_ADD;
            mac_ctrl.acc_sel = SEL_D2;
            mac_ctrl.rnd_sel = SEL_D1;
            dly_wr_en        = 1'b1;
            state_in         = ST_P7;
         end
         ST_P7: begin
            mac_ctrl.rnd_sel  = SEL_D2;
            mac_ctrl.x_from_y = 1'b1;
            dly_wr_en         = 1'b1;
            dly_wr_odd        = 1'b1;
            if (stage_ff == last_ff) begin
               state_in = ST_DONE;
            end else begin
               // Fetch b0 and d1 of the next stage while this one retires.
               stage_in   = stage_next;
               rd_stage   = stage_next;
               rd_slot    = SLOT_B0;
               coef_rd_en = 1'b1;
               dly_rd_en  = 1'b1;
               state_in   = ST_P1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign coef_rd_addr = coef_addr(CAW'(rd_stage), rd_slot);
   assign coef_wr_addr = coef_addr(CAW'(req_coef_stage), req_coef_slot);
   assign dly_rd_addr  = {rd_stage, dly_rd_odd};
   assign dly_wr_addr  = {stage_ff, dly_wr_odd};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = y;
         rsp_last_in  = blk_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff    <= stage_in;
      last_ff     <= last_in;
      blk_ff      <= blk_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- src/biquad_cascade_df2t_filter.sv -----
`timescale 1ns / 1ps
// Cascade of direct form II transposed biquad sections on one shared multiply-accumulate unit.
// A coefficient-load word is taken while idle and produces no result.
// A sample word with N stages in use runs them all, then loads its result and raises rsp_tvalid;
// the next word is accepted only after that, and a stalled output register holds it back.
// Each stage takes seven steps of the single multiplier: five products and two delay writes.
// Reset sets the stage count to one and clears the valid bits, so coefficients and delays read 0.
module biquad_cascade_df2t_filter #(
   parameter int MAX_STAGES = bcd_pkg::DEF_MAX_STAGES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sample_in[31:0], coef_stage[34:32], coef_slot[37:35], coef_value[69:38], zero fill
   input  logic [71:0] req_tdata,
   // op
   input  logic        req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // sample_out[31:0]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data
);

   import bcd_pkg::*;

   localparam int SW  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
   localparam int DAW = SW + 1;
   localparam int CAW = $clog2(NUM_COEF * MAX_STAGES);

   logic [3:0]            num_stages_ff, num_stages_in;
   logic [SW-1:0]         last_stage;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic [2:0]            coef_stage;
   logic [2:0]            coef_slot;
   logic [SAMPLE_W-1:0]   coef_value;
   mac_ctrl_type          mac_ctrl;
   logic                  coef_wr_en, coef_rd_en;
   logic [CAW-1:0]        coef_wr_addr, coef_rd_addr;
   logic [SAMPLE_W-1:0]   coef_rd_data;
   logic                  dly_wr_en, dly_rd_en;
   logic [DAW-1:0]        dly_wr_addr, dly_rd_addr;
   logic [SAMPLE_W-1:0]   dly_rd_data;
   logic signed [SAMPLE_W-1:0] rnd_out;
   logic signed [SAMPLE_W-1:0] y;

   assign sample_in  = req_tdata[31:0];
   assign coef_stage = req_tdata[34:32];
   assign coef_slot  = req_tdata[37:35];
   assign coef_value = req_tdata[69:38];

   assign csr_ready     = 1'b1;
   assign num_stages_in = (csr_valid && csr_ready) ? csr_data : num_stages_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_stages_ff <= 4'd1;
      end else begin
         num_stages_ff <= num_stages_in;
      end
   end

   // A stage count of zero runs one stage; a count above the built depth runs them all.
   always_comb begin
      if (num_stages_ff == '0) begin
         last_stage = '0;
      end else if (32'(num_stages_ff) > MAX_STAGES) begin
         last_stage = SW'(MAX_STAGES - 1);
      end else begin
         last_stage = SW'(num_stages_ff - 4'd1);
      end
   end

   bcd_seq #(
      .MAX_STAGES(MAX_STAGES),
      .SW        (SW),
      .CAW       (CAW),
      .DAW       (DAW)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_op        (req_tuser),
      .req_block_end (req_tlast),
      .req_coef_stage(coef_stage),
      .req_coef_slot (coef_slot),
      .last_stage    (last_stage),
      .y             (y),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .mac_ctrl      (mac_ctrl),
      .coef_wr_en    (coef_wr_en),
      .coef_wr_addr  (coef_wr_addr),
      .coef_rd_en    (coef_rd_en),
      .coef_rd_addr  (coef_rd_addr),
      .dly_rd_en     (dly_rd_en),
      .dly_rd_addr   (dly_rd_addr),
      .dly_wr_en     (dly_wr_en),
      .dly_wr_addr   (dly_wr_addr)
   );

   bcd_ram #(
      .DEPTH(NUM_COEF * MAX_STAGES),
      .AW   (CAW),
      .W    (SAMPLE_W)
   ) u_coef_ram (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (coef_wr_en),
      .wr_addr(coef_wr_addr),
      .wr_data(coef_value),
      .rd_en  (coef_rd_en),
      .rd_addr(coef_rd_addr),
      .rd_data(coef_rd_data)
   );

   bcd_ram #(
      .DEPTH(2 * MAX_STAGES),
      .AW   (DAW),
      .W    (SAMPLE_W)
   ) u_dly_ram (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (dly_wr_en),
      .wr_addr(dly_wr_addr),
      .wr_data(rnd_out),
      .rd_en  (dly_rd_en),
      .rd_addr(dly_rd_addr),
      .rd_data(dly_rd_data)
   );

   bcd_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .sample (sample_in),
      .coef_rd(coef_rd_data),
      .dly_rd (dly_rd_data),
      .rnd_out(rnd_out),
      .y_out  (y)
   );

endmodule

// ----- tb/sv/biquad_cascade_df2t_filter_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the biquad cascade filter with a bit-exact fixed-point predictor.
module biquad_cascade_df2t_filter_tb;
   import bcd_pkg::*;

   localparam int MAX_STAGES = DEF_MAX_STAGES;
   localparam int SIW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
   localparam int PERIOD = 10;
   localparam int RESET_CYCLES = 7;
   // Covers the longest sample; a load word may still be in flight after the last result.
   localparam int SETTLE_CYCLES = 64;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int PHASE_WORDS = 118;

   localparam logic [31:0] Q31_POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q31_NEG_MAX = 32'h8000_0000;
   localparam logic [31:0] Q30_UNITY   = 32'h4000_0000;
   localparam longint Q31_HI = 64'sd2147483647;
   localparam longint Q31_LO = -64'sd2147483648;
   localparam logic [2:0] SLOT_BAD_LO = 3'd5;
   localparam logic [2:0] SLOT_BAD_HI = 3'd7;

   typedef struct packed {
      logic        op;
      logic [31:0] sample;
      logic        block_end;
      logic [2:0]  stage;
      logic [2:0]  slot;
      logic [31:0] value;
      logic        typed;
      logic [31:0] typed_out;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] sample;
      logic        last;
   } out_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_data = '0;

   // Predictor state.
   logic signed [31:0] coef_mem [MAX_STAGES][NUM_COEF];
   logic signed [31:0] delay_mem [MAX_STAGES][2];
   logic [3:0]         stage_count;

   out_word_type  expected_out [$];
   stim_row_type  directed [$];
   int            error_count = 0;
   int            cycle_count = 0;
   int            hold_left = 0;
   bit            stalls_on = 1'b1;

   biquad_cascade_df2t_filter #(
      .MAX_STAGES(MAX_STAGES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Q3.61 product brought to Q5.59 with a floor shift.
   function automatic longint scaled_product(input logic signed [31:0] c,
                                             input logic signed [31:0] v);
      longint p;
      p = longint'(c) * longint'(v);
      return p >>> 2;
   endfunction

   function automatic logic [31:0] round_q31(input longint acc);
      longint r;
      r = (acc + (longint'(1) <<< 27)) >>> 28;
      if (r > Q31_HI) return Q31_POS_MAX;
      if (r < Q31_LO) return Q31_NEG_MAX;
      return r[31:0];
   endfunction

   function automatic logic [31:0] cascade_output(input logic [31:0] sample);
      int n;
      logic signed [31:0] x, y, nd1, nd2;
      n = int'(stage_count);
      if (n == 0) n = 1;
      if (n > MAX_STAGES) n = MAX_STAGES;
      x = sample;
      for (int s = 0; s < n; s++) begin
         y = round_q31(scaled_product(coef_mem[SIW'(s)][SLOT_B0], x)
                       + (longint'(delay_mem[SIW'(s)][1'b0]) <<< DLY_SHIFT));
         nd1 = round_q31(scaled_product(coef_mem[SIW'(s)][SLOT_B1], x)
                         + scaled_product(coef_mem[SIW'(s)][SLOT_A1], y)
                         + (longint'(delay_mem[SIW'(s)][1'b1]) <<< DLY_SHIFT));
         nd2 = round_q31(scaled_product(coef_mem[SIW'(s)][SLOT_B2], x)
                         + scaled_product(coef_mem[SIW'(s)][SLOT_A2], y));
         delay_mem[SIW'(s)][1'b0] = nd1;
         delay_mem[SIW'(s)][1'b1] = nd2;
         x = y;
      end
      return x;
   endfunction

   // Applies one accepted word to the predictor and queues its result, if any.
   function automatic void take_word(input stim_row_type w);
      out_word_type o;
      if (w.op == OP_LOAD) begin
         if (32'(w.slot) < NUM_COEF && 32'(w.stage) < MAX_STAGES)
            coef_mem[SIW'(w.stage)][w.slot] = w.value;
      end else begin
         o.sample = cascade_output(w.sample);
         if (w.typed) o.sample = w.typed_out;
         o.last = w.block_end;
         expected_out.push_back(o);
      end
   endfunction

   function automatic stim_row_type sample_row(input logic [31:0] x, input logic last,
                                               input logic typed, input logic [31:0] y);
      stim_row_type r;
      r = '0;
      r.op = OP_FILTER;
      r.sample = x;
      r.block_end = last;
      r.typed = typed;
      r.typed_out = y;
      return r;
   endfunction

   function automatic stim_row_type coef_row(input logic [2:0] stage, input logic [2:0] slot,
                                             input logic [31:0] value);
      stim_row_type r;
      r = '0;
      r.op = OP_LOAD;
      r.stage = stage;
      r.slot = slot;
      r.value = value;
      return r;
   endfunction

   function automatic logic [31:0] extreme_value();
      case ($urandom_range(0, 3))
         0: return Q31_POS_MAX;
         1: return Q31_NEG_MAX;
         2: return Q30_UNITY;
         default: return '0;
      endcase
   endfunction

   // Mostly small, stable coefficients so the filters run long without saturating.
   function automatic stim_row_type random_word();
      stim_row_type r;
      int pick;
      r.sample = $urandom;
      r.block_end = ($urandom_range(0, 3) == 0);
      r.stage = 3'($urandom_range(0, 7));
      r.slot = 3'($urandom_range(0, 4));
      r.value = $urandom;
      r.typed = 1'b0;
      r.typed_out = '0;
      if ($urandom_range(0, 3) == 0) begin
         r.op = OP_LOAD;
         if ($urandom_range(0, 9) == 0) r.slot = 3'($urandom_range(SLOT_BAD_LO, SLOT_BAD_HI));
         pick = $urandom_range(0, 99);
         if (pick < 70)
            r.value = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
         else if (pick < 85)
            r.value = extreme_value();
      end else begin
         r.op = OP_FILTER;
         if ($urandom_range(0, 6) == 0) r.sample = extreme_value();
      end
      return r;
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic send_word(input stim_row_type w, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= w.op;
      req_tlast <= w.block_end;
      req_tdata <= {2'b00, w.value, w.slot, w.stage, w.sample};
      do @(posedge clock); while (!req_tready);
      take_word(w);
   endtask

   // Holds the input off until every queued result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_out.size() != 0) @(posedge clock);
   endtask

   task automatic write_stage_count(input logic [3:0] n);
      csr_valid <= 1'b1;
      csr_data <= n;
      do @(posedge clock); while (!csr_ready);
      stage_count = n;
      csr_valid <= 1'b0;
   endtask

   // Receiver side: random back-pressure.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (stalls_on) hold_left = idle_gap();
      end
   end

   always @(posedge clock) begin
      out_word_type e;
      if (rsp_tvalid && rsp_tready) begin
         if (expected_out.size() == 0) begin
            $error("unexpected result word: sample_out %h block_last %b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            e = expected_out.pop_front();
            if (rsp_tdata !== e.sample) begin
               $error("sample_out: expected %h, got %h", e.sample, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== e.last) begin
               $error("block_last: expected %b, got %b", e.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [3:0] settings [8];
      int gap;
      coef_mem = '{default: '0};
      delay_mem = '{default: '0};
      stage_count = 4'd1;
      settings = '{4'd0, 4'd15, 4'd8, 4'd3, 4'd1, 4'd5, 4'd0, 4'd0};
      settings[6] = 4'($urandom_range(0, 15));
      settings[7] = 4'($urandom_range(0, 15));

      // With all coefficients zero the output is zero; b0 of one passes the sample through.
      directed = '{
         sample_row(Q31_POS_MAX, 1'b1, 1'b1, 32'h0),
         sample_row(Q31_NEG_MAX, 1'b0, 1'b1, 32'h0),
         coef_row(3'd0, SLOT_B0, Q30_UNITY),
         sample_row(Q31_POS_MAX, 1'b0, 1'b1, Q31_POS_MAX),
         sample_row(Q31_NEG_MAX, 1'b1, 1'b1, Q31_NEG_MAX),
         coef_row(3'd0, SLOT_BAD_LO, 32'h0),
         sample_row(32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678),
         coef_row(3'd0, SLOT_BAD_HI, 32'h0),
         sample_row(32'hEDCB_A988, 1'b1, 1'b1, 32'hEDCB_A988),
         coef_row(3'd0, SLOT_B0, Q31_POS_MAX),
         sample_row(Q31_POS_MAX, 1'b0, 1'b1, Q31_POS_MAX),
         coef_row(3'd0, SLOT_B0, Q31_NEG_MAX),
         sample_row(Q31_NEG_MAX, 1'b0, 1'b1, Q31_POS_MAX),
         sample_row(Q31_POS_MAX, 1'b1, 1'b1, Q31_NEG_MAX),
         coef_row(3'd0, SLOT_B1, 32'h2000_0000),
         coef_row(3'd0, SLOT_B2, 32'hE000_0000),
         coef_row(3'd0, SLOT_A1, 32'h3000_0000),
         coef_row(3'd0, SLOT_A2, 32'hF000_0000),
         coef_row(3'd0, SLOT_B0, Q30_UNITY),
         sample_row(32'h4000_0000, 1'b0, 1'b0, 32'h0),
         sample_row(32'hC000_0000, 1'b0, 1'b0, 32'h0),
         sample_row(32'h0000_0000, 1'b1, 1'b0, 32'h0),
         coef_row(3'd7, SLOT_A2, Q31_POS_MAX),
         coef_row(3'd7, SLOT_B0, Q31_NEG_MAX),
         sample_row(Q31_POS_MAX, 1'b0, 1'b0, 32'h0)
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_word(directed[i], idle_gap());

      for (int phase = 0; phase < 8; phase++) begin
         drain_results();
         repeat (SETTLE_CYCLES) @(posedge clock);
         write_stage_count(settings[3'(phase)]);
         // One phase runs with no idling on either side.
         stalls_on = (phase != 2);
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if ($urandom_range(0, 99) == 0) drain_results();
            gap = stalls_on ? idle_gap() : 0;
            send_word(random_word(), gap);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
